>>> hw/rtl/pll_pkg.sv
// Shared constants and types for the positional list engine.
package pll_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IW         = $clog2(LIST_DEPTH);
  localparam int CW         = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 4;
  localparam int POS_W      = 8;
  localparam int STAT_W     = 3;
  localparam int CNT_OUT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_END   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_READ_FWD  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_READ_BACK = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REVERSE   = 4'd8;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  // UP: cell lo loads the bus, cells above it up to hi take the left neighbor.
  // DOWN: cells lo..hi-1 take the right neighbor, cell hi loads the bus.
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_UP,
    MODE_DOWN
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t        mode;
    logic [IW-1:0]     lo;
    logic [IW-1:0]     hi;
    logic [DATA_W-1:0] bus;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/pll_cell.sv
// One storage cell of the list chain.
module pll_cell (
  input  logic                          clk,
  input  logic [pll_pkg::IW-1:0]        idx,
  input  pll_pkg::cell_ctrl_t           ctrl,
  input  logic [pll_pkg::DATA_W-1:0]    left,
  input  logic [pll_pkg::DATA_W-1:0]    right,
  output logic [pll_pkg::DATA_W-1:0]    data
);

  logic [pll_pkg::DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.mode)
      pll_pkg::MODE_UP: begin
        if (idx == ctrl.lo) begin
          data_next = ctrl.bus;
        end else if (idx > ctrl.lo && idx <= ctrl.hi) begin
          data_next = left;
        end
      end
      pll_pkg::MODE_DOWN: begin
        if (idx == ctrl.hi) begin
          data_next = ctrl.bus;
        end else if (idx >= ctrl.lo && idx < ctrl.hi) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hw/rtl/positional_list_engine.sv
// Positional list engine: top level with command sequencer and cell chain.
// Single-result commands (inserts, deletes, unknown codes) finish on their
// transfer: any chain shift happens at once, and a new transfer can be taken
// every cycle while the result side keeps up. A read-out starts the cycle after
// its transfer and emits one entry per cycle while the result side keeps up, by
// rotating the chain, and the list ends where it started. Reverse returns its
// result at once and then rotates the tail into place slot by slot. Until the
// engine is back in idle, no input transfer is taken.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // command[3:0], value[35:4], position[43:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[2:0], value_out[34:3], count_out[39:35]
  output logic        m_tlast
);

  localparam int IW = pll_pkg::IW;
  localparam int CW = pll_pkg::CW;
  localparam int DW = pll_pkg::DATA_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_REV
  } state_t;

  state_t                    state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [CW-1:0]             rem, rem_next;
  logic [IW-1:0]             rev_k, rev_k_next;
  logic                      read_back, read_back_next;

  logic [DW-1:0]             cell_data [pll_pkg::LIST_DEPTH];
  pll_pkg::cell_ctrl_t       ctrl;

  logic                      out_free, in_fire, out_load;
  logic [pll_pkg::STAT_W-1:0] out_status;
  logic [DW-1:0]             out_value;
  logic                      out_last;

  logic [pll_pkg::CMD_W-1:0] cmd;
  logic [DW-1:0]             val;
  logic [pll_pkg::POS_W-1:0] pos, pos_m1;
  logic [CW-1:0]             cnt_m1;
  logic [IW-1:0]             pos_idx, last_idx, count_idx, rd_idx;
  logic [DW-1:0]             rd_data;
  logic                      empty, full;

  assign cmd       = s_tdata[3:0];
  assign val       = s_tdata[35:4];
  assign pos       = s_tdata[43:36];
  assign pos_m1    = pos - 8'd1;
  assign cnt_m1    = count - CW'(1);
  assign pos_idx   = pos_m1[IW-1:0];
  assign last_idx  = cnt_m1[IW-1:0];
  assign count_idx = count[IW-1:0];
  assign empty     = (count == '0);
  assign full      = (count == CW'(pll_pkg::LIST_DEPTH));

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign in_fire   = s_tvalid && s_tready;

  assign rd_idx    = (state == ST_IDLE && cmd == pll_pkg::CMD_DEL_POS) ? pos_idx : last_idx;
  assign rd_data   = cell_data[rd_idx];

  for (genvar i = 0; i < pll_pkg::LIST_DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = ctrl.bus;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == pll_pkg::LIST_DEPTH - 1) begin : g_last
      assign right_in = ctrl.bus;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    pll_cell u_cell (
      .clk   (clk),
      .idx   (IW'(i)),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i])
    );
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rem_next       = rem;
    rev_k_next     = rev_k;
    read_back_next = read_back;
    ctrl.mode      = pll_pkg::MODE_HOLD;
    ctrl.lo        = '0;
    ctrl.hi        = last_idx;
    ctrl.bus       = rd_data;
    out_load       = 1'b0;
    out_status     = pll_pkg::STAT_OK;
    out_value      = '0;
    out_last       = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (cmd)
            pll_pkg::CMD_INS_FRONT, pll_pkg::CMD_INS_END: begin
              if (full) begin
                out_status = pll_pkg::STAT_FULL;
              end else begin
                ctrl.mode  = pll_pkg::MODE_UP;
                ctrl.lo    = (cmd == pll_pkg::CMD_INS_END) ? count_idx : '0;
                ctrl.hi    = count_idx;
                ctrl.bus   = val;
                count_next = count + CW'(1);
              end
            end
            pll_pkg::CMD_INS_POS: begin
              if (pos == '0) begin
                out_status = pll_pkg::STAT_INVALID;
              end else if (9'(pos) > 9'(count) + 9'd1) begin
                out_status = pll_pkg::STAT_RANGE;
              end else if (full) begin
                out_status = pll_pkg::STAT_FULL;
              end else begin
                ctrl.mode  = pll_pkg::MODE_UP;
                ctrl.lo    = pos_idx;
                ctrl.hi    = count_idx;
                ctrl.bus   = val;
                count_next = count + CW'(1);
              end
            end
            pll_pkg::CMD_DEL_FRONT: begin
              if (empty) begin
                out_status = pll_pkg::STAT_EMPTY;
              end else begin
                out_value  = cell_data[0];
                ctrl.mode  = pll_pkg::MODE_DOWN;
                count_next = cnt_m1;
              end
            end
            pll_pkg::CMD_DEL_END: begin
              if (empty) begin
                out_status = pll_pkg::STAT_EMPTY;
              end else begin
                out_value  = rd_data;
                ctrl.mode  = pll_pkg::MODE_DOWN;
                ctrl.lo    = last_idx;
                count_next = cnt_m1;
              end
            end
            pll_pkg::CMD_DEL_POS: begin
              if (empty) begin
                out_status = pll_pkg::STAT_EMPTY;
              end else if (pos == '0) begin
                out_status = pll_pkg::STAT_INVALID;
              end else if (9'(pos) > 9'(count)) begin
                out_status = pll_pkg::STAT_RANGE;
              end else begin
                out_value  = rd_data;
                ctrl.mode  = pll_pkg::MODE_DOWN;
                ctrl.lo    = pos_idx;
                count_next = cnt_m1;
              end
            end
            pll_pkg::CMD_READ_FWD, pll_pkg::CMD_READ_BACK: begin
              if (empty) begin
                out_status = pll_pkg::STAT_EMPTY;
              end else begin
                out_load       = 1'b0;
                state_next     = ST_READ;
                rem_next       = count;
                read_back_next = (cmd == pll_pkg::CMD_READ_BACK);
              end
            end
            pll_pkg::CMD_REVERSE: begin
              if (empty) begin
                out_status = pll_pkg::STAT_EMPTY;
              end else if (count != CW'(1)) begin
                state_next = ST_REV;
                rev_k_next = '0;
              end
            end
            default: out_status = pll_pkg::STAT_OK;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_last  = (rem == CW'(1));
          rem_next  = rem - CW'(1);
          if (read_back) begin
            out_value = rd_data;
            ctrl.mode = pll_pkg::MODE_UP;
            ctrl.bus  = rd_data;
          end else begin
            out_value = cell_data[0];
            ctrl.mode = pll_pkg::MODE_DOWN;
            ctrl.bus  = cell_data[0];
          end
          if (rem == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REV: begin
        // move the current tail to slot rev_k
        ctrl.mode  = pll_pkg::MODE_UP;
        ctrl.lo    = rev_k;
        ctrl.bus   = rd_data;
        rev_k_next = rev_k + IW'(1);
        if (CW'(rev_k) + CW'(2) == count) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rem       <= '0;
      rev_k     <= '0;
      read_back <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rem       <= rem_next;
      rev_k     <= rev_k_next;
      read_back <= read_back_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {pll_pkg::CNT_OUT_W'(count_next), out_value, out_status};
      m_tlast <= out_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(pll_pkg::LIST_DEPTH))
    else $error("entry count above list depth");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> count == $past(count))
    else $error("entry count changed during read-out or reverse");

  a_read_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> rem != '0 && rem <= count)
    else $error("read-out counter out of bounds");

  a_rev_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_REV |-> CW'(rev_k) + CW'(2) <= count)
    else $error("reverse step past end of list");

  a_read_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ && out_free && rem == CW'(1) |=> m_tvalid && m_tlast)
    else $error("final read-out transfer not marked last");

endmodule

>>> dv/pll_checker.sv
// Checker for the positional list engine: tracks the list, predicts results, compares.
module pll_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // command[3:0], value[35:4], position[43:36]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // status[2:0], value_out[34:3], count_out[39:35]
  input  logic        m_tlast,
  output int          errors,
  output int          due_count,
  output int          list_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pll_pkg::STAT_W-1:0]    status;
    logic [pll_pkg::DATA_W-1:0]    value;
    logic                          last;
    logic [pll_pkg::CNT_OUT_W-1:0] count;
  } list_result_t;

  logic [pll_pkg::DATA_W-1:0] cells [pll_pkg::LIST_DEPTH];
  int                         cells_used;
  list_result_t               due_results [$];

  task automatic run_list_command(input logic [pll_pkg::CMD_W-1:0]  cmd,
                                  input logic [pll_pkg::DATA_W-1:0] val,
                                  input logic [pll_pkg::POS_W-1:0]  pos);
    logic [pll_pkg::STAT_W-1:0] st;
    logic [pll_pkg::DATA_W-1:0] removed;
    logic [pll_pkg::DATA_W-1:0] swap;
    int                         ins_at;
    int                         del_at;
    int                         idx;
    st      = pll_pkg::STAT_OK;
    removed = '0;
    ins_at  = -1;
    del_at  = -1;
    case (cmd)
      pll_pkg::CMD_INS_FRONT: ins_at = 0;
      pll_pkg::CMD_INS_END:   ins_at = cells_used;
      pll_pkg::CMD_INS_POS: begin
        if (pos == '0) st = pll_pkg::STAT_INVALID;
        else if (int'(pos) > cells_used + 1) st = pll_pkg::STAT_RANGE;
        else ins_at = int'(pos) - 1;
      end
      pll_pkg::CMD_DEL_FRONT: begin
        if (cells_used == 0) st = pll_pkg::STAT_EMPTY;
        else del_at = 0;
      end
      pll_pkg::CMD_DEL_END: begin
        if (cells_used == 0) st = pll_pkg::STAT_EMPTY;
        else del_at = cells_used - 1;
      end
      pll_pkg::CMD_DEL_POS: begin
        if (cells_used == 0) st = pll_pkg::STAT_EMPTY;
        else if (pos == '0) st = pll_pkg::STAT_INVALID;
        else if (int'(pos) > cells_used) st = pll_pkg::STAT_RANGE;
        else del_at = int'(pos) - 1;
      end
      pll_pkg::CMD_READ_FWD, pll_pkg::CMD_READ_BACK: begin
        if (cells_used == 0) begin
          st = pll_pkg::STAT_EMPTY;
        end else begin
          for (int k = 0; k < cells_used; k++) begin
            idx = (cmd == pll_pkg::CMD_READ_FWD) ? k : cells_used - 1 - k;
            due_results.push_back('{pll_pkg::STAT_OK, cells[idx], (k == cells_used - 1),
                                    pll_pkg::CNT_OUT_W'(cells_used)});
          end
          return;
        end
      end
      pll_pkg::CMD_REVERSE: begin
        if (cells_used == 0) begin
          st = pll_pkg::STAT_EMPTY;
        end else begin
          for (int k = 0; k < cells_used / 2; k++) begin
            swap                      = cells[k];
            cells[k]                  = cells[cells_used - 1 - k];
            cells[cells_used - 1 - k] = swap;
          end
        end
      end
      default: ;
    endcase
    if (ins_at >= 0) begin
      if (cells_used >= pll_pkg::LIST_DEPTH) begin
        st = pll_pkg::STAT_FULL;
      end else begin
        for (int k = cells_used; k > ins_at; k--) cells[k] = cells[k - 1];
        cells[ins_at] = val;
        cells_used++;
      end
    end
    if (del_at >= 0) begin
      removed = cells[del_at];
      for (int k = del_at; k < cells_used - 1; k++) cells[k] = cells[k + 1];
      cells_used--;
    end
    due_results.push_back('{st, removed, 1'b1, pll_pkg::CNT_OUT_W'(cells_used)});
  endtask

  // Sample at the falling edge: a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (rst) begin
      cells_used = 0;
      errors     = 0;
      due_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        run_list_command(s_tdata[3:0], s_tdata[35:4], s_tdata[43:36]);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[34:3], m_tlast, m_tdata[39:35]};
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: actual status=%0d value=%0d %s",
                   $time, got.status, $signed(got.value),
                   $sformatf("last=%0b count=%0d", got.last, got.count));
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected status=%0d value=%0d last=%0b count=%0d",
                     $time, want.status, $signed(want.value), want.last, want.count);
            $display("%0t:           actual   status=%0d value=%0d last=%0b count=%0d",
                     $time, got.status, $signed(got.value), got.last, got.count);
          end
        end
      end
    end
    due_count = due_results.size();
    list_len  = cells_used;
  end

endmodule

>>> dv/tb_positional_list_engine.sv
// Testbench top for the positional list engine: clock, reset, stimulus, verdict.
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS   = 88;
  localparam int CALM_ITEMS   = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * pll_pkg::LIST_DEPTH + 8;

  localparam logic [pll_pkg::DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [pll_pkg::DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [pll_pkg::DATA_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int errors;
  int due_count;
  int list_len;
  int quiet_cycles = 0;
  bit calm         = 1'b0;

  always #4 clk = ~clk;

  positional_list_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  pll_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .due_count (due_count),
    .list_len  (list_len)
  );

  // Called and returns at a rising edge; the transfer happens at the returning edge.
  task automatic send_cmd(input logic [pll_pkg::CMD_W-1:0]  cmd,
                          input logic [pll_pkg::DATA_W-1:0] val,
                          input logic [pll_pkg::POS_W-1:0]  pos);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, pos, val, cmd};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // phase 0 grows the list, 1 mixes, 2 drains it
  task automatic send_random(input int phase);
    int                         roll;
    int                         ins_w;
    int                         del_w;
    logic [pll_pkg::CMD_W-1:0]  cmd;
    logic [pll_pkg::DATA_W-1:0] val;
    logic [pll_pkg::POS_W-1:0]  pos;
    ins_w = (phase == 0) ? 85 : (phase == 1) ? 40 : 15;
    del_w = (phase == 0) ? 5 : (phase == 1) ? 35 : 65;
    roll  = $urandom_range(0, 99);
    if (roll < ins_w) begin
      cmd = pll_pkg::CMD_INS_FRONT + pll_pkg::CMD_W'($urandom_range(0, 2));
    end else if (roll < ins_w + del_w) begin
      cmd = pll_pkg::CMD_DEL_FRONT + pll_pkg::CMD_W'($urandom_range(0, 2));
    end else if (roll < 94) begin
      cmd = $urandom_range(0, 1) ? pll_pkg::CMD_READ_FWD : pll_pkg::CMD_READ_BACK;
    end else if (roll < 98) begin
      cmd = pll_pkg::CMD_REVERSE;
    end else begin
      cmd = pll_pkg::CMD_REVERSE + pll_pkg::CMD_W'($urandom_range(1, 7));
    end
    case ($urandom_range(0, 7))
      0:       val = VAL_MIN;
      1:       val = VAL_MAX;
      2:       val = $urandom_range(0, 1) ? '0 : VAL_ONES;
      default: val = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       pos = '0;
      1:       pos = pll_pkg::POS_W'($urandom);
      default: pos = pll_pkg::POS_W'($urandom_range(1, list_len + 1));
    endcase
    send_cmd(cmd, val, pos);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_cmd(pll_pkg::CMD_REVERSE, '0, '0);
    send_cmd(pll_pkg::CMD_READ_FWD, '0, '0);
    send_cmd(pll_pkg::CMD_READ_BACK, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_FRONT, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_END, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_POS, '0, '0);
    send_cmd(pll_pkg::CMD_INS_POS, VAL_ONES, '0);
    send_cmd(pll_pkg::CMD_INS_POS, VAL_ONES, 8'd2);
    // build, probe positions, read, reverse, tear down
    send_cmd(pll_pkg::CMD_INS_POS, VAL_MIN, 8'd1);
    send_cmd(pll_pkg::CMD_INS_FRONT, VAL_MAX, 8'hFF);
    send_cmd(pll_pkg::CMD_INS_END, VAL_ONES, '0);
    send_cmd(pll_pkg::CMD_INS_POS, '0, 8'd4);
    send_cmd(pll_pkg::CMD_INS_POS, VAL_ONES, 8'hFF);
    send_cmd(pll_pkg::CMD_DEL_POS, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_POS, '0, 8'd5);
    send_cmd(pll_pkg::CMD_READ_FWD, '0, '0);
    send_cmd(pll_pkg::CMD_REVERSE, '0, '0);
    send_cmd(pll_pkg::CMD_READ_BACK, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_POS, VAL_ONES, 8'd2);
    send_cmd(pll_pkg::CMD_DEL_END, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_FRONT, '0, '0);
    send_cmd(pll_pkg::CMD_REVERSE + pll_pkg::CMD_W'(7), VAL_ONES, 8'hFF);
    send_cmd(pll_pkg::CMD_REVERSE, '0, '0);
    send_cmd(pll_pkg::CMD_DEL_POS, '0, 8'd1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      send_random((n / 22) % 3);
    end
    s_tvalid <= 1'b0;

    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pll_pkg.sv
hw/rtl/pll_cell.sv
hw/rtl/positional_list_engine.sv
dv/pll_checker.sv
dv/tb_positional_list_engine.sv
